[rtl/core/xcrc_pkg.sv]
// ----------------------------------------------------------------------------
// xcrc_pkg
// Shared types, protocol byte codes and the CRC-16 byte update for the
// XMODEM-CRC receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xcrc_pkg;

	localparam int PACKET_BYTES = 128;
	localparam int PKT_IDX_W    = $clog2(PACKET_BYTES);
	localparam int STORED_W     = 17;
	localparam int MAX_RESULTS  = 3;

	localparam logic [7:0] SOH_BYTE = 8'h01;
	localparam logic [7:0] EOT_BYTE = 8'h04;
	localparam logic [7:0] ACK_BYTE = 8'h06;
	localparam logic [7:0] CAN_BYTE = 8'h18;
	localparam logic [7:0] C_BYTE   = 8'h43;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [STORED_W-1:0] CAPACITY_RESET = 17'h10000;

	typedef enum logic {
		OP_BYTE  = 1'b0,
		OP_START = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_STORE  = 2'd0,
		KIND_REPLY  = 2'd1,
		KIND_FINISH = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ERROR   = 2'd1,
		ST_OVERRUN = 2'd2
	} status_t;

	// one result, less its buffer address
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [7:0] reply;
		status_t    status;
	} res_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

[rtl/core/xmodem_crc_receiver_unit.sv]
// ----------------------------------------------------------------------------
// xmodem_crc_receiver_unit
// XMODEM-CRC receiver: one link byte or start command per input transaction,
// store / reply / finish results out, one per output transaction.
// An accepted item is registered, then its results are written to the result queue.
// Throughput: one item per cycle while items cause at most one result each
// and out_stall is low; an item with k results takes k transactions. Input is held
// off while the 4-entry result queue lacks room for a three-result burst.
// Reset: async, clears phase to idle, sequence to 1, capacity to 65536.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xmodem_crc_receiver_unit import xcrc_pkg::*; #(
	parameter int ADDR_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  opcode,
	input  logic [7:0]            rx_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            kind,
	output logic [ADDR_BITS-1:0]  address,
	output logic [7:0]            data_byte,
	output logic [7:0]            reply_byte,
	output logic [1:0]            status,
	output logic                  last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [STORED_W-1:0]   capacity_bytes
);

	localparam int ENTRY_W = 2 + ADDR_BITS + 8 + 8 + 2 + 1;

	logic                   valid_s1;
	opcode_t                opcode_s1;
	logic [7:0]             rx_byte_s1;
	logic [STORED_W-1:0]    capacity_q;
	logic                   room;
	logic                   fire_s1;
	logic [1:0]             res_cnt;
	res_t [MAX_RESULTS-1:0] res;
	logic [ADDR_BITS-1:0]   store_addr;
	logic [1:0]             wr_cnt;
	logic [MAX_RESULTS-1:0][ENTRY_W-1:0] wr_data;
	logic [ENTRY_W-1:0]     rd_data;

	assign cfg_ready = 1'b1;
	assign fire_s1   = valid_s1 && room;
	assign in_stall  = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= capacity_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			opcode_s1  <= opcode_t'(opcode);
			rx_byte_s1 <= rx_byte;
		end
	end

	xcrc_proto #(
		.ADDR_BITS(ADDR_BITS)
	) u_proto (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire_s1),
		.opcode     (opcode_s1),
		.rx_byte    (rx_byte_s1),
		.capacity   (capacity_q),
		.res_cnt    (res_cnt),
		.res        (res),
		.store_addr (store_addr)
	);

	assign wr_cnt = res_cnt;

	always_comb begin
		for (int k = 0; k < MAX_RESULTS; k++) begin
			wr_data[k] = {res[k].kind,
				(k == 0) ? store_addr : {ADDR_BITS{1'b0}},
				res[k].data, res[k].reply, res[k].status,
				(2'(k) == res_cnt - 2'd1)};
		end
	end

	xcrc_rqueue #(
		.WIDTH(ENTRY_W),
		.DEPTH(4)
	) u_rqueue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cnt   (wr_cnt),
		.wr_data  (wr_data),
		.room     (room),
		.rd_valid (out_valid),
		.rd_stall (out_stall),
		.rd_data  (rd_data)
	);

	assign {kind, address, data_byte, reply_byte, status, last} = rd_data;

`ifndef NO_ASSERTIONS
	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !room) |=> (valid_s1 && $stable(rx_byte_s1) && $stable(opcode_s1)))
		else $error("held input item lost while result queue was full");
`endif

endmodule

[rtl/core/xcrc_rqueue.sv]
// ----------------------------------------------------------------------------
// xcrc_rqueue
// Result queue: takes up to three results per cycle, hands out one per
// output transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcrc_rqueue import xcrc_pkg::*; #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [1:0]                       wr_cnt,
	input  logic [MAX_RESULTS-1:0][WIDTH-1:0] wr_data,
	output logic                             room,
	output logic                             rd_valid,
	input  logic                             rd_stall,
	output logic [WIDTH-1:0]                 rd_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = PTR_W + 1;

	logic [DEPTH-1:0][WIDTH-1:0] mem_q;
	logic [PTR_W-1:0]            wr_ptr_q;
	logic [PTR_W-1:0]            rd_ptr_q;
	logic [CNT_W-1:0]            count_q;
	logic                        pop;

	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign pop      = rd_valid && !rd_stall;
	// room for a worst-case burst
	assign room     = (count_q <= CNT_W'(DEPTH - MAX_RESULTS));

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_RESULTS; k++) begin
			if (2'(k) < wr_cnt) begin
				mem_q[wr_ptr_q + PTR_W'(k)] <= wr_data[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(wr_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(wr_cnt) - CNT_W'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("result queue overflow");

	a_burst_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_cnt != 2'd0) |-> (CNT_W'(wr_cnt) <= CNT_W'(DEPTH) - count_q))
		else $error("result burst written without room");
`endif

endmodule

[rtl/core/xcrc_proto.sv]
// ----------------------------------------------------------------------------
// xcrc_proto
// Protocol state machine: packet framing, sequence check, CRC-16 and result
// generation for one received byte or start command per cycle in which fire is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcrc_proto import xcrc_pkg::*; #(
	parameter int ADDR_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  opcode_t                     opcode,
	input  logic [7:0]                  rx_byte,
	input  logic [STORED_W-1:0]         capacity,
	output logic [1:0]                  res_cnt,
	output res_t [MAX_RESULTS-1:0]      res,
	output logic [ADDR_BITS-1:0]        store_addr
);

	localparam int SUM_W = (ADDR_BITS > STORED_W) ? ADDR_BITS : STORED_W;

	typedef enum logic [7:0] {
		PH_IDLE   = 8'b0000_0001,
		PH_HEADER = 8'b0000_0010,
		PH_SEQ    = 8'b0000_0100,
		PH_SEQINV = 8'b0000_1000,
		PH_DATA   = 8'b0001_0000,
		PH_CRCH   = 8'b0010_0000,
		PH_CRCL   = 8'b0100_0000,
		PH_DONE   = 8'b1000_0000
	} phase_t;

	phase_t                phase_q, phase_d;
	logic [7:0]            exp_seq_q, exp_seq_d;
	logic [7:0]            seq_byte_q, seq_byte_d;
	logic                  seq_bad_q, seq_bad_d;
	logic [PKT_IDX_W-1:0]  idx_q, idx_d;
	logic [15:0]           crc_q, crc_d;
	logic [7:0]            crc_high_q, crc_high_d;
	logic [STORED_W-1:0]   stored_q, stored_d;
	logic [SUM_W-1:0]      addr_sum;
	logic [STORED_W:0]     need;

	assign addr_sum   = SUM_W'(stored_q) + SUM_W'(idx_q);
	assign need       = {1'b0, stored_q} + (STORED_W + 1)'(PACKET_BYTES);

	always_comb begin
		phase_d    = phase_q;
		exp_seq_d  = exp_seq_q;
		seq_byte_d = seq_byte_q;
		seq_bad_d  = seq_bad_q;
		idx_d      = idx_q;
		crc_d      = crc_q;
		crc_high_d = crc_high_q;
		stored_d   = stored_q;
		res_cnt    = 2'd0;
		res        = '0;
		store_addr = '0;
		if (fire) begin
			if (opcode == OP_START) begin
				exp_seq_d    = 8'd1;
				stored_d     = '0;
				seq_bad_d    = 1'b0;
				idx_d        = '0;
				crc_d        = '0;
				phase_d      = PH_HEADER;
				res_cnt      = 2'd1;
				res[0].kind  = KIND_REPLY;
				res[0].reply = C_BYTE;
			end else begin
				case (phase_q)
					PH_HEADER: begin
						if (rx_byte == SOH_BYTE) begin
							if (need > {1'b0, capacity}) begin
								res_cnt       = 2'd1;
								res[0].kind   = KIND_FINISH;
								res[0].status = ST_OVERRUN;
								phase_d       = PH_DONE;
							end else begin
								phase_d = PH_SEQ;
							end
						end else if (rx_byte == EOT_BYTE) begin
							res_cnt       = 2'd2;
							res[0].kind   = KIND_REPLY;
							res[0].reply  = ACK_BYTE;
							res[1].kind   = KIND_FINISH;
							res[1].status = ST_OK;
							phase_d       = PH_DONE;
						end else begin
							res_cnt       = 2'd1;
							res[0].kind   = KIND_FINISH;
							res[0].status = ST_OK;
							phase_d       = PH_DONE;
						end
					end
					PH_SEQ: begin
						seq_byte_d = rx_byte;
						phase_d    = PH_SEQINV;
					end
					PH_SEQINV: begin
						seq_bad_d = (seq_byte_q != exp_seq_q) || (rx_byte != ~exp_seq_q);
						idx_d     = '0;
						crc_d     = '0;
						phase_d   = PH_DATA;
					end
					PH_DATA: begin
						res_cnt     = 2'd1;
						res[0].kind = KIND_STORE;
						res[0].data = rx_byte;
						store_addr  = addr_sum[ADDR_BITS-1:0];
						crc_d       = crc_update(crc_q, rx_byte);
						idx_d       = idx_q + PKT_IDX_W'(1);
						// index wraps to zero after the last data byte
						if (idx_q == PKT_IDX_W'(PACKET_BYTES - 1)) begin
							phase_d = PH_CRCH;
						end
					end
					PH_CRCH: begin
						crc_high_d = rx_byte;
						phase_d    = PH_CRCL;
					end
					PH_CRCL: begin
						if (({crc_high_q, rx_byte} == crc_q) && !seq_bad_q) begin
							res_cnt      = 2'd1;
							res[0].kind  = KIND_REPLY;
							res[0].reply = ACK_BYTE;
							stored_d     = stored_q + STORED_W'(PACKET_BYTES);
							exp_seq_d    = exp_seq_q + 8'd1;
							phase_d      = PH_HEADER;
						end else begin
							res_cnt       = 2'd3;
							res[0].kind   = KIND_REPLY;
							res[0].reply  = CAN_BYTE;
							res[1].kind   = KIND_REPLY;
							res[1].reply  = ACK_BYTE;
							res[2].kind   = KIND_FINISH;
							res[2].status = ST_ERROR;
							phase_d       = PH_DONE;
						end
					end
					default: begin
						// idle or finished: byte dropped
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			exp_seq_q  <= 8'd1;
			seq_byte_q <= '0;
			seq_bad_q  <= 1'b0;
			idx_q      <= '0;
			crc_q      <= '0;
			crc_high_q <= '0;
			stored_q   <= '0;
		end else begin
			phase_q    <= phase_d;
			exp_seq_q  <= exp_seq_d;
			seq_byte_q <= seq_byte_d;
			seq_bad_q  <= seq_bad_d;
			idx_q      <= idx_d;
			crc_q      <= crc_d;
			crc_high_q <= crc_high_d;
			stored_q   <= stored_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_start_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && opcode == OP_START) |=> (phase_q == PH_HEADER && stored_q == '0))
		else $error("start command did not reopen the transfer");

	a_crc_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && opcode == OP_BYTE && phase_q == PH_CRCL)
		|=> (phase_q == PH_HEADER || phase_q == PH_DONE))
		else $error("packet end left an unexpected phase");
`endif

endmodule
